@@ rtl/core/smsi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsi_pkg
// shared types and constants of the system msi target table
// ----------------------------------------------------------------------------
package smsi_pkg;

  localparam int NUM_ENTRIES = 8;
  localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CNT_W       = 4;
  localparam int HALF_W      = 32;
  localparam int ADDR_W      = 64;
  localparam int WRITE_BYTES = 4;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 64;

  localparam logic [CNT_W-1:0]  COUNT_RESET = 4'd8;
  localparam logic [ADDR_W-1:0] BASE_RESET  = '0;
  localparam logic [ADDR_W-1:0] LAST_RESET  = '1;

  typedef enum logic [1:0] {
    REG_COUNT = 2'd0,
    REG_BASE  = 2'd1,
    REG_LAST  = 2'd2,
    REG_NONE  = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    CMD_ATTRS      = 3'd0,
    CMD_MSI_ATTRS  = 3'd1,
    CMD_SET_STATE  = 3'd2,
    CMD_GET_STATE  = 3'd3,
    CMD_SET_TARGET = 3'd4,
    CMD_GET_TARGET = 3'd5,
    CMD_SEND       = 3'd6,
    CMD_UNKNOWN    = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_BAD_PARAM = 3'd1,
    STS_BAD_ADDR  = 3'd2,
    STS_BAD_STATE = 3'd3,
    STS_NOT_SUPP  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic [CNT_W-1:0]  msi_count;
    logic [ADDR_W-1:0] window_base;
    logic [ADDR_W-1:0] window_last;
  } cfg_t;

  typedef struct packed {
    logic              enabled;
    logic [ADDR_W-1:0] address;
    logic [HALF_W-1:0] data;
  } entry_t;

  typedef struct packed {
    cmd_e              cmd;
    logic              idx_ok;
    logic              win_ok;
    logic              en_bit;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] address;
    logic [HALF_W-1:0] data;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic              status_only;
    logic [CNT_W-1:0]  count;
    logic              enable;
    logic [HALF_W-1:0] rd_addr_lo;
    logic [HALF_W-1:0] rd_addr_hi;
    logic [HALF_W-1:0] rd_data;
    logic              msi_valid;
    logic [ADDR_W-1:0] msi_address;
    logic [HALF_W-1:0] msi_data;
  } res_t;

endpackage

@@ rtl/core/smsi_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsi_cfg_regs
// apb register file: entry count and target address window
// ----------------------------------------------------------------------------
module smsi_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [smsi_pkg::PADDR_W-1:0] paddr,
  input  logic [smsi_pkg::PDATA_W-1:0] pwdata,
  output logic [smsi_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output smsi_pkg::cfg_t               cfg_o
);

  smsi_pkg::cfg_t cfg_q, cfg_d;
  smsi_pkg::reg_e sel;
  logic           wr_en;

  // registers sit on 8-byte boundaries
  assign sel    = smsi_pkg::reg_e'(paddr[4:3]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        smsi_pkg::REG_COUNT: cfg_d.msi_count   = pwdata[smsi_pkg::CNT_W-1:0];
        smsi_pkg::REG_BASE:  cfg_d.window_base = pwdata;
        smsi_pkg::REG_LAST:  cfg_d.window_last = pwdata;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      smsi_pkg::REG_COUNT: prdata = {{(smsi_pkg::PDATA_W-smsi_pkg::CNT_W){1'b0}},
                                     cfg_q.msi_count};
      smsi_pkg::REG_BASE:  prdata = cfg_q.window_base;
      smsi_pkg::REG_LAST:  prdata = cfg_q.window_last;
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.msi_count   <= smsi_pkg::COUNT_RESET;
      cfg_q.window_base <= smsi_pkg::BASE_RESET;
      cfg_q.window_last <= smsi_pkg::LAST_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/smsi_entry_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smsi_entry_ram
// entry table memory, one read and one write port, registered read data
// ----------------------------------------------------------------------------
module smsi_entry_ram (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [smsi_pkg::IDX_W-1:0] rd_idx_i,
  output smsi_pkg::entry_t           rd_entry_o,
  input  logic                       wr_en_i,
  input  logic [smsi_pkg::IDX_W-1:0] wr_idx_i,
  input  smsi_pkg::entry_t           wr_entry_i
);

  smsi_pkg::entry_t                   mem [smsi_pkg::NUM_ENTRIES];
  smsi_pkg::entry_t                   rd_q;
  logic [smsi_pkg::NUM_ENTRIES-1:0]   valid_q;
  logic                               rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_idx_i];
    end
  end

  // an entry never written since reset reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_idx_i];
      end
    end
  end

  assign rd_entry_o = rd_valid_q ? rd_q : '0;

endmodule

@@ rtl/core/system_msi_target_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// system_msi_target_table
// system msi entry table: count, attributes, enable, target and msi send
// ----------------------------------------------------------------------------
// channel   dir  handshake                   payload
// in        in   in_valid_i / in_ready_o     command .. new_data
// out       out  out_valid_o / out_ready_i   status .. msi_write_data
// cfg       in   psel penable pwrite pready  paddr pwdata prdata
//
// a normal request is accepted in the idle state, which reads the entry
// memory; the lookup state forms the reply and writes back, and the reply is
// offered from the hold state on.
// the reply waits in the hold state while out_ready_i stays low, and
// the next word is accepted in the cycle after the reply leaves.
// a posted request is accepted while idle and produces no reply.
// reset clears the table at once through per-entry valid bits.
// ----------------------------------------------------------------------------
module system_msi_target_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   command_i,
  input  logic                         normal_request_i,
  input  logic [31:0]                  entry_index_i,
  input  logic [31:0]                  state_word_i,
  input  logic [31:0]                  new_address_low_i,
  input  logic [31:0]                  new_address_high_i,
  input  logic [31:0]                  new_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2:0]                   status_o,
  output logic                         status_only_o,
  output logic [3:0]                   reported_count_o,
  output logic                         reported_enable_o,
  output logic [31:0]                  read_address_low_o,
  output logic [31:0]                  read_address_high_o,
  output logic [31:0]                  read_data_o,
  output logic                         msi_write_valid_o,
  output logic [63:0]                  msi_write_address_o,
  output logic [31:0]                  msi_write_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [smsi_pkg::PADDR_W-1:0] paddr,
  input  logic [smsi_pkg::PDATA_W-1:0] pwdata,
  output logic [smsi_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  smsi_pkg::cfg_t   cfg;
  smsi_pkg::state_e state_q, state_d;
  smsi_pkg::req_t   req_q, req_d;
  smsi_pkg::res_t   res_q, res_d;
  smsi_pkg::entry_t rd_entry, wr_entry;
  logic             wr_en;
  logic             accept;
  logic [smsi_pkg::CNT_W-1:0]  live_count;
  logic [smsi_pkg::ADDR_W-1:0] new_addr;
  logic [smsi_pkg::ADDR_W:0]   addr_end;

  smsi_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  smsi_entry_ram u_ram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_idx_i   (entry_index_i[smsi_pkg::IDX_W-1:0]),
    .rd_entry_o (rd_entry),
    .wr_en_i    (wr_en),
    .wr_idx_i   (req_q.idx),
    .wr_entry_i (wr_entry)
  );

  assign in_ready_o = (state_q == smsi_pkg::ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  assign live_count = (32'(cfg.msi_count) > smsi_pkg::NUM_ENTRIES)
                    ? smsi_pkg::CNT_W'(smsi_pkg::NUM_ENTRIES) : cfg.msi_count;

  // last byte of the four-byte write, carry out means it wraps
  assign new_addr = {new_address_high_i, new_address_low_i};
  assign addr_end = {1'b0, new_addr} + (smsi_pkg::ADDR_W+1)'(smsi_pkg::WRITE_BYTES - 1);

  always_comb begin
    req_d = req_q;
    if (accept) begin
      req_d.cmd     = smsi_pkg::cmd_e'(command_i);
      req_d.idx_ok  = entry_index_i < {{(32-smsi_pkg::CNT_W){1'b0}}, live_count};
      req_d.win_ok  = (new_addr >= cfg.window_base) && !addr_end[smsi_pkg::ADDR_W]
                   && (addr_end[smsi_pkg::ADDR_W-1:0] <= cfg.window_last);
      req_d.en_bit  = state_word_i[0];
      req_d.idx     = entry_index_i[smsi_pkg::IDX_W-1:0];
      req_d.address = new_addr;
      req_d.data    = new_data_i;
    end
  end

  always_comb begin
    state_d  = state_q;
    res_d    = res_q;
    wr_en    = 1'b0;
    wr_entry = rd_entry;
    unique case (state_q)
      smsi_pkg::ST_IDLE: begin
        if (accept && normal_request_i) begin
          state_d = smsi_pkg::ST_LOOKUP;
        end
      end
      smsi_pkg::ST_LOOKUP: begin
        res_d             = '0;
        res_d.status      = smsi_pkg::STS_OK;
        res_d.status_only = 1'b1;
        state_d           = smsi_pkg::ST_HOLD;
        priority if (req_q.cmd == smsi_pkg::CMD_UNKNOWN) begin
          res_d.status = smsi_pkg::STS_NOT_SUPP;
        end else if (req_q.cmd == smsi_pkg::CMD_ATTRS) begin
          res_d.status_only = 1'b0;
          res_d.count       = live_count;
        end else if (!req_q.idx_ok) begin
          res_d.status = smsi_pkg::STS_BAD_PARAM;
        end else begin
          unique case (req_q.cmd)
            smsi_pkg::CMD_MSI_ATTRS: res_d.status_only = 1'b0;
            smsi_pkg::CMD_SET_STATE: begin
              wr_en            = 1'b1;
              wr_entry.enabled = req_q.en_bit;
            end
            smsi_pkg::CMD_GET_STATE: begin
              res_d.status_only = 1'b0;
              res_d.enable      = rd_entry.enabled;
            end
            smsi_pkg::CMD_SET_TARGET: begin
              if (req_q.win_ok) begin
                wr_en            = 1'b1;
                wr_entry.address = req_q.address;
                wr_entry.data    = req_q.data;
              end else begin
                res_d.status = smsi_pkg::STS_BAD_ADDR;
              end
            end
            smsi_pkg::CMD_GET_TARGET: begin
              res_d.status_only = 1'b0;
              res_d.rd_addr_lo  = rd_entry.address[smsi_pkg::HALF_W-1:0];
              res_d.rd_addr_hi  = rd_entry.address[smsi_pkg::ADDR_W-1:smsi_pkg::HALF_W];
              res_d.rd_data     = rd_entry.data;
            end
            smsi_pkg::CMD_SEND: begin
              if (!rd_entry.enabled || (rd_entry.address == '0)) begin
                res_d.status = smsi_pkg::STS_BAD_STATE;
              end else begin
                res_d.msi_valid   = 1'b1;
                res_d.msi_address = rd_entry.address;
                res_d.msi_data    = rd_entry.data;
              end
            end
            default: res_d.status = smsi_pkg::STS_NOT_SUPP;
          endcase
        end
      end
      smsi_pkg::ST_HOLD: begin
        if (out_ready_i) begin
          state_d = smsi_pkg::ST_IDLE;
        end
      end
      default: state_d = smsi_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smsi_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
  end

  assign out_valid_o         = (state_q == smsi_pkg::ST_HOLD);
  assign status_o            = res_q.status;
  assign status_only_o       = res_q.status_only;
  assign reported_count_o    = res_q.count;
  assign reported_enable_o   = res_q.enable;
  assign read_address_low_o  = res_q.rd_addr_lo;
  assign read_address_high_o = res_q.rd_addr_hi;
  assign read_data_o         = res_q.rd_data;
  assign msi_write_valid_o   = res_q.msi_valid;
  assign msi_write_address_o = res_q.msi_address;
  assign msi_write_data_o    = res_q.msi_data;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// system_msi_target_table testbench
// drives requests through the valid/ready input, programs the count and the
// address window over apb, and checks every reply word against a table model
// kept in step with each accepted request
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    smsi_pkg::cmd_e cmd;
    logic           normal;
    logic [31:0]    idx;
    logic [31:0]    state;
    logic [31:0]    addr_lo;
    logic [31:0]    addr_hi;
    logic [31:0]    data;
  } request_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic [2:0]                   command_i;
  logic                         normal_request_i;
  logic [31:0]                  entry_index_i;
  logic [31:0]                  state_word_i;
  logic [31:0]                  new_address_low_i;
  logic [31:0]                  new_address_high_i;
  logic [31:0]                  new_data_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic [2:0]                   status_o;
  logic                         status_only_o;
  logic [3:0]                   reported_count_o;
  logic                         reported_enable_o;
  logic [31:0]                  read_address_low_o;
  logic [31:0]                  read_address_high_o;
  logic [31:0]                  read_data_o;
  logic                         msi_write_valid_o;
  logic [63:0]                  msi_write_address_o;
  logic [31:0]                  msi_write_data_o;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [smsi_pkg::PADDR_W-1:0] paddr;
  logic [smsi_pkg::PDATA_W-1:0] pwdata;
  logic [smsi_pkg::PDATA_W-1:0] prdata;
  logic                         pready;

  // table and register image
  logic              tbl_en   [smsi_pkg::NUM_ENTRIES];
  logic [63:0]       tbl_addr [smsi_pkg::NUM_ENTRIES];
  logic [31:0]       tbl_data [smsi_pkg::NUM_ENTRIES];
  logic [3:0]        cfg_count;
  logic [63:0]       cfg_base;
  logic [63:0]       cfg_last;

  smsi_pkg::res_t    reply_q[$];
  int unsigned       mismatch_cnt = 0;
  int unsigned       cycle_cnt = 0;
  int unsigned       rx_hold = 0;
  bit                tx_idle = 1'b1;
  bit                rx_idle = 1'b1;

  system_msi_target_table u_top (.*);

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("system_msi_target_table regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  function automatic logic [31:0] live_count();
    return (cfg_count > smsi_pkg::NUM_ENTRIES) ? 32'(smsi_pkg::NUM_ENTRIES)
                                               : 32'(cfg_count);
  endfunction

  // the four-byte write must sit inside [base, last] without wrapping
  function automatic bit target_allowed(input logic [63:0] a);
    if (a < cfg_base) return 1'b0;
    if (a > 64'hFFFF_FFFF_FFFF_FFFC) return 1'b0;
    return (a + 64'd3) <= cfg_last;
  endfunction

  function automatic bit predict_reply(input request_t rq, output smsi_pkg::res_t rs);
    logic [31:0] live;
    logic [63:0] a;
    int          e;
    rs = '0;
    if (!rq.normal) return 1'b0;
    live = live_count();
    rs.status = smsi_pkg::STS_OK;
    rs.status_only = 1'b1;
    if (rq.cmd == smsi_pkg::CMD_UNKNOWN) begin
      rs.status = smsi_pkg::STS_NOT_SUPP;
    end else if (rq.cmd == smsi_pkg::CMD_ATTRS) begin
      rs.status_only = 1'b0;
      rs.count = live[3:0];
    end else if (rq.idx >= live) begin
      rs.status = smsi_pkg::STS_BAD_PARAM;
    end else begin
      e = int'(rq.idx);
      case (rq.cmd)
        smsi_pkg::CMD_MSI_ATTRS: begin
          rs.status_only = 1'b0;
        end
        smsi_pkg::CMD_SET_STATE: begin
          tbl_en[e] = rq.state[0];
        end
        smsi_pkg::CMD_GET_STATE: begin
          rs.status_only = 1'b0;
          rs.enable = tbl_en[e];
        end
        smsi_pkg::CMD_SET_TARGET: begin
          a = {rq.addr_hi, rq.addr_lo};
          if (!target_allowed(a)) begin
            rs.status = smsi_pkg::STS_BAD_ADDR;
          end else begin
            tbl_addr[e] = a;
            tbl_data[e] = rq.data;
          end
        end
        smsi_pkg::CMD_GET_TARGET: begin
          rs.status_only = 1'b0;
          rs.rd_addr_lo = tbl_addr[e][31:0];
          rs.rd_addr_hi = tbl_addr[e][63:32];
          rs.rd_data = tbl_data[e];
        end
        default: begin
          if (!tbl_en[e] || tbl_addr[e] == 64'd0) begin
            rs.status = smsi_pkg::STS_BAD_STATE;
          end else begin
            rs.msi_valid = 1'b1;
            rs.msi_address = tbl_addr[e];
            rs.msi_data = tbl_data[e];
          end
        end
      endcase
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk_i) begin : reply_check
    smsi_pkg::res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (reply_q.size() == 0) begin
        report_mismatch("reply with no request pending", 64'(status_o), 64'd0);
      end else begin
        want = reply_q.pop_front();
        check_field("status", 64'(status_o), 64'(want.status));
        check_field("status_only", 64'(status_only_o), 64'(want.status_only));
        check_field("reported_count", 64'(reported_count_o), 64'(want.count));
        check_field("reported_enable", 64'(reported_enable_o), 64'(want.enable));
        check_field("read_address_low", 64'(read_address_low_o), 64'(want.rd_addr_lo));
        check_field("read_address_high", 64'(read_address_high_o),
                    64'(want.rd_addr_hi));
        check_field("read_data", 64'(read_data_o), 64'(want.rd_data));
        check_field("msi_write_valid", 64'(msi_write_valid_o), 64'(want.msi_valid));
        check_field("msi_write_address", msi_write_address_o, want.msi_address);
        check_field("msi_write_data", 64'(msi_write_data_o), 64'(want.msi_data));
      end
    end
  end

  // reply side: random stalls, or one long hold when asked
  initial begin : reply_sink
    int unsigned n;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold > 0) begin
        n = rx_hold;
        rx_hold = 0;
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else begin
        n = rx_idle ? $urandom_range(0, 7) : 0;
        if (n > 0) begin
          out_ready_i <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
        @(posedge clk_i);
        while (!out_valid_o && rx_hold == 0) @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------- driving

  task automatic send_word(input request_t rq);
    int unsigned    gap;
    smsi_pkg::res_t rs;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    command_i          <= rq.cmd;
    normal_request_i   <= rq.normal;
    entry_index_i      <= rq.idx;
    state_word_i       <= rq.state;
    new_address_low_i  <= rq.addr_lo;
    new_address_high_i <= rq.addr_hi;
    new_data_i         <= rq.data;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (predict_reply(rq, rs)) reply_q.push_back(rs);
  endtask

  task automatic issue(input smsi_pkg::cmd_e c, input logic [31:0] idx,
                       input logic [31:0] st, input logic [63:0] a,
                       input logic [31:0] d, input logic normal = 1'b1);
    request_t rq;
    rq.cmd = c;
    rq.normal = normal;
    rq.idx = idx;
    rq.state = st;
    rq.addr_lo = a[31:0];
    rq.addr_hi = a[63:32];
    rq.data = d;
    send_word(rq);
  endtask

  // stop offering words, let every reply come back, then let a posted word settle
  task automatic wait_replies();
    in_valid_i <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input smsi_pkg::reg_e r, input logic [63:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 3'b000};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      smsi_pkg::REG_COUNT: cfg_count = v[3:0];
      smsi_pkg::REG_BASE:  cfg_base = v;
      smsi_pkg::REG_LAST:  cfg_last = v;
      default: ;
    endcase
  endtask

  task automatic set_window(input logic [63:0] base, input logic [63:0] last);
    apb_write(smsi_pkg::REG_BASE, base);
    apb_write(smsi_pkg::REG_LAST, last);
  endtask

  function automatic logic [63:0] pick_target();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return cfg_base + 64'($urandom_range(0, 255));
    if (sel < 7) return cfg_last - 64'($urandom_range(0, 8));
    return {$urandom, $urandom};
  endfunction

  function automatic request_t rand_request();
    request_t    rq;
    int unsigned pick;
    logic [31:0] live;
    logic [63:0] a;
    pick = $urandom_range(0, 99);
    if (pick < 4)       rq.cmd = smsi_pkg::CMD_ATTRS;
    else if (pick < 10) rq.cmd = smsi_pkg::CMD_MSI_ATTRS;
    else if (pick < 26) rq.cmd = smsi_pkg::CMD_SET_STATE;
    else if (pick < 34) rq.cmd = smsi_pkg::CMD_GET_STATE;
    else if (pick < 54) rq.cmd = smsi_pkg::CMD_SET_TARGET;
    else if (pick < 64) rq.cmd = smsi_pkg::CMD_GET_TARGET;
    else if (pick < 94) rq.cmd = smsi_pkg::CMD_SEND;
    else                rq.cmd = smsi_pkg::CMD_UNKNOWN;
    rq.normal = ($urandom_range(0, 9) != 0);
    live = live_count();
    pick = $urandom_range(0, 19);
    if (pick < 16 && live > 0) rq.idx = $urandom_range(0, live - 1);
    else if (pick < 19)        rq.idx = $urandom_range(0, 15);
    else                       rq.idx = $urandom;
    rq.state = $urandom;
    a = pick_target();
    rq.addr_lo = a[31:0];
    rq.addr_hi = a[63:32];
    rq.data = $urandom;
    return rq;
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    issue(smsi_pkg::CMD_ATTRS, 0, 0, 0, 0);
    issue(smsi_pkg::CMD_MSI_ATTRS, 0, 0, 0, 0);
    issue(smsi_pkg::CMD_MSI_ATTRS, 7, 0, 0, 0);
    issue(smsi_pkg::CMD_MSI_ATTRS, 8, 0, 0, 0);
    issue(smsi_pkg::CMD_GET_STATE, 32'hFFFF_FFFF, 0, 0, 0);
    issue(smsi_pkg::CMD_GET_STATE, 0, 0, 0, 0);
    issue(smsi_pkg::CMD_GET_TARGET, 3, 0, 0, 0);
    issue(smsi_pkg::CMD_SEND, 0, 0, 0, 0);                     // disabled
    issue(smsi_pkg::CMD_SET_STATE, 0, 32'h0000_0001, 0, 0);
    issue(smsi_pkg::CMD_SEND, 0, 0, 0, 0);                     // enabled, address zero
    issue(smsi_pkg::CMD_SET_TARGET, 0, 0, 64'hFFFF_FFFF_FFFF_FFFC, 32'hFFFF_FFFF);
    issue(smsi_pkg::CMD_SET_TARGET, 0, 0, 64'hFFFF_FFFF_FFFF_FFFD, 32'h1234_5678);
    issue(smsi_pkg::CMD_SEND, 0, 0, 0, 0);
    issue(smsi_pkg::CMD_SET_STATE, 7, 32'hFFFF_FFFE, 0, 0);
    issue(smsi_pkg::CMD_GET_STATE, 7, 0, 0, 0);
    issue(smsi_pkg::CMD_SET_TARGET, 7, 0, 64'd0, 32'hDEAD_BEEF);  // zero target
    issue(smsi_pkg::CMD_GET_TARGET, 7, 0, 0, 0);
    issue(smsi_pkg::CMD_UNKNOWN, 0, 0, 0, 0);
    issue(smsi_pkg::CMD_SET_STATE, 0, 32'd0, 0, 0, 1'b0);      // posted: no effect
    issue(smsi_pkg::CMD_SEND, 0, 0, 0, 0, 1'b0);
    issue(smsi_pkg::CMD_SET_TARGET, 0, 0, 64'h1000, 0, 1'b0);
    issue(smsi_pkg::CMD_SEND, 0, 0, 0, 0);
    issue(smsi_pkg::CMD_GET_TARGET, 0, 0, 0, 0);
    wait_replies();
  endtask

  task automatic test_counts();
    apb_write(smsi_pkg::REG_COUNT, 64'd1);
    issue(smsi_pkg::CMD_ATTRS, 0, 0, 0, 0);
    issue(smsi_pkg::CMD_GET_STATE, 0, 0, 0, 0);
    issue(smsi_pkg::CMD_GET_STATE, 1, 0, 0, 0);
    wait_replies();
    apb_write(smsi_pkg::REG_COUNT, 64'd0);
    issue(smsi_pkg::CMD_ATTRS, 0, 0, 0, 0);
    issue(smsi_pkg::CMD_MSI_ATTRS, 0, 0, 0, 0);
    wait_replies();
    apb_write(smsi_pkg::REG_COUNT, 64'hF);                     // clamps to the table size
    issue(smsi_pkg::CMD_ATTRS, 0, 0, 0, 0);
    issue(smsi_pkg::CMD_SEND, 8, 0, 0, 0);
    issue(smsi_pkg::CMD_GET_TARGET, 7, 0, 0, 0);
    wait_replies();
    apb_write(smsi_pkg::REG_COUNT, 64'hFFFF_FFFF_FFFF_FFF3);   // only the low nibble counts
    issue(smsi_pkg::CMD_ATTRS, 0, 0, 0, 0);
    issue(smsi_pkg::CMD_SEND, 3, 0, 0, 0);
    wait_replies();
    apb_write(smsi_pkg::REG_COUNT, 64'd8);
  endtask

  task automatic test_window();
    set_window(64'h1000, 64'h1FFF);
    issue(smsi_pkg::CMD_SET_TARGET, 1, 0, 64'h0FFF, 32'h1);
    issue(smsi_pkg::CMD_SET_TARGET, 1, 0, 64'h1000, 32'hA5A5_A5A5);
    issue(smsi_pkg::CMD_SET_TARGET, 1, 0, 64'h1FFC, 32'h5A5A_5A5A);
    issue(smsi_pkg::CMD_SET_TARGET, 1, 0, 64'h1FFD, 32'h2);
    issue(smsi_pkg::CMD_SET_TARGET, 1, 0, 64'hFFFF_FFFF_0000_1000, 32'h3);
    issue(smsi_pkg::CMD_GET_TARGET, 1, 0, 0, 0);
    wait_replies();
    set_window(64'h2000, 64'h1000);                            // empty window
    issue(smsi_pkg::CMD_SET_TARGET, 1, 0, 64'h1800, 32'h4);
    wait_replies();
    set_window(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    issue(smsi_pkg::CMD_SET_TARGET, 2, 0, 64'hFFFF_FFFF_FFFF_FFFF, 32'h5);
    issue(smsi_pkg::CMD_SET_TARGET, 2, 0, 64'hFFFF_FFFF_FFFF_FFFC, 32'h6);
    wait_replies();
    set_window(64'd0, 64'd0);
    issue(smsi_pkg::CMD_SET_TARGET, 2, 0, 64'd0, 32'h7);
    wait_replies();
    apb_write(smsi_pkg::REG_LAST, 64'd3);
    issue(smsi_pkg::CMD_SET_TARGET, 2, 0, 64'd0, 32'h8);
    issue(smsi_pkg::CMD_SET_TARGET, 2, 0, 64'd1, 32'h9);
    issue(smsi_pkg::CMD_GET_TARGET, 2, 0, 0, 0);
    wait_replies();
    set_window(64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  // hold the reply side long enough for the block to stall its input
  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold = 80;
    repeat (20) send_word(rand_request());
    wait_replies();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: ;
        1: begin
          apb_write(smsi_pkg::REG_COUNT, 64'd3);
          set_window(64'h8000_0000_0000_0000, 64'h8000_0000_0000_FFFF);
        end
        2: begin
          apb_write(smsi_pkg::REG_COUNT, 64'd5);
          set_window(64'h1000, 64'h1FFF_FFFF);
        end
        3: begin
          apb_write(smsi_pkg::REG_COUNT, 64'd8);
          set_window(64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        end
        default: begin
          apb_write(smsi_pkg::REG_COUNT, 64'd12);
          set_window(64'hFFFF_FFFF_FFFF_F000, 64'hFFFF_FFFF_FFFF_FFFF);
        end
      endcase
      for (int i = 0; i < 90; i++) begin
        if (i % 30 == 0) begin
          tx_idle = ($urandom_range(0, 3) != 0);
          rx_idle = ($urandom_range(0, 3) != 0);
        end
        if (i == 45) wait_replies();                  // sender pauses mid-phase
        send_word(rand_request());
      end
      wait_replies();
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin : main_seq
    for (int e = 0; e < smsi_pkg::NUM_ENTRIES; e++) begin
      tbl_en[e] = 1'b0;
      tbl_addr[e] = '0;
      tbl_data[e] = '0;
    end
    cfg_count = smsi_pkg::COUNT_RESET;
    cfg_base = smsi_pkg::BASE_RESET;
    cfg_last = smsi_pkg::LAST_RESET;
    rst_ni             <= 1'b0;
    in_valid_i         <= 1'b0;
    command_i          <= smsi_pkg::CMD_ATTRS;
    normal_request_i   <= 1'b0;
    entry_index_i      <= '0;
    state_word_i       <= '0;
    new_address_low_i  <= '0;
    new_address_high_i <= '0;
    new_data_i         <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_counts();
    test_window();
    test_backpressure();
    test_random();
    wait_replies();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("system_msi_target_table regression: pass");
    end else begin
      $display("system_msi_target_table regression: fail");
    end
    $finish;
  end

endmodule
